[design/assert_macros.svh]
// Assertion macros used by the checker file ccs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: always");

// Implication checked in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

[design/ccs_pkg.sv]
// Types, constants and step-angle function for the CORDIC sine/cosine block.
`default_nettype none
package ccs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AngleW = 16;
  localparam int unsigned OutW   = 16;

  localparam logic [AngleW-1:0] TWO_PI        = 16'd51472;
  localparam logic [AngleW-1:0] THREE_HALF_PI = 16'd38604;
  localparam logic [AngleW-1:0] PI_ANG        = 16'd25736;
  localparam logic [AngleW-1:0] HALF_PI       = 16'd12868;

  localparam logic signed [WordW-1:0] START_ANGLE  = 32'sd421657428;
  localparam logic signed [WordW-1:0] START_VECTOR = 32'sd652032874;
  localparam logic signed [OutW-1:0]  OUT_LIMIT    = 16'sd16384;

  localparam int unsigned AtanN = 10;

  localparam logic [WordW-1:0] ATAN_TBL [AtanN] = '{
    32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843, 32'd16771758,
    32'd8387925,   32'd4194219,   32'd2097141,  32'd1048575,  32'd524288
  };

  typedef struct packed {
    logic                     neg_cos;
    logic                     neg_sin;
    logic signed [WordW-1:0]  cx;
    logic signed [WordW-1:0]  sy;
    logic signed [WordW-1:0]  acc;
    logic signed [WordW-1:0]  target;
  } ccs_vec_t;

  // step angle used by rotation step 'step' (1-based); halves past the table
  function automatic logic [WordW-1:0] rot_of(input int step);
    logic [WordW-1:0] r;
    if (step <= AtanN) begin
      r = ATAN_TBL[step-1];
    end else begin
      r = ATAN_TBL[AtanN-1] >> (step - AtanN);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/ccs_fold.sv]
// Input stage: range reduction, quadrant folding and CORDIC seed.
`default_nettype none
module ccs_fold (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req,
  input  logic [15:0]           angle,
  output logic                  vld_o,
  output ccs_pkg::ccs_vec_t     d_o
);
  import ccs_pkg::*;

  logic [AngleW-1:0] a_red;
  logic [AngleW-1:0] a_fold;
  logic              neg_cos;
  logic              neg_sin;
  logic              vld_r;
  ccs_vec_t          d_r;
  ccs_vec_t          d_nxt;

  always_comb begin
    a_red   = (angle > TWO_PI) ? angle - TWO_PI : angle;
    a_fold  = a_red;
    neg_cos = 1'b0;
    neg_sin = 1'b0;
    if (a_red > THREE_HALF_PI) begin
      a_fold  = TWO_PI - a_red;
      neg_sin = 1'b1;
    end else if (a_red > PI_ANG) begin
      a_fold  = a_red - PI_ANG;
      neg_cos = 1'b1;
      neg_sin = 1'b1;
    end else if (a_red > HALF_PI) begin
      a_fold  = PI_ANG - a_red;
      neg_cos = 1'b1;
    end
    d_nxt.neg_cos = neg_cos;
    d_nxt.neg_sin = neg_sin;
    d_nxt.cx      = START_VECTOR;
    d_nxt.sy      = START_VECTOR;
    d_nxt.acc     = START_ANGLE;
    d_nxt.target  = $signed({a_fold, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule
`default_nettype wire

[design/ccs_stage.sv]
// One rotation-mode CORDIC step with its pipeline register.
`default_nettype none
module ccs_stage #(
  parameter int STEP = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  ccs_pkg::ccs_vec_t d_i,
  output logic              vld_o,
  output ccs_pkg::ccs_vec_t d_o
);
  import ccs_pkg::*;

  localparam logic signed [WordW-1:0] Rot = $signed(rot_of(STEP));

  logic signed [WordW-1:0] sy_sh;
  logic signed [WordW-1:0] cx_sh;
  logic                    up;
  logic                    vld_r;
  ccs_vec_t                d_r;
  ccs_vec_t                d_nxt;

  always_comb begin
    sy_sh = d_i.sy >>> STEP;
    cx_sh = d_i.cx >>> STEP;
    up    = d_i.target > d_i.acc;
    d_nxt = d_i;
    if (up) begin
      d_nxt.cx  = d_i.cx - sy_sh;
      d_nxt.sy  = d_i.sy + cx_sh;
      d_nxt.acc = d_i.acc + Rot;
    end else begin
      d_nxt.cx  = d_i.cx + sy_sh;
      d_nxt.sy  = d_i.sy - cx_sh;
      d_nxt.acc = d_i.acc - Rot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule
`default_nettype wire

[design/ccs_out.sv]
// Output stage: take upper half, saturate, apply quadrant signs.
`default_nettype none
module ccs_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  ccs_pkg::ccs_vec_t   d_i,
  output logic                out_valid,
  output logic signed [15:0]  out_cosine,
  output logic signed [15:0]  out_sine
);
  import ccs_pkg::*;

  logic signed [OutW-1:0] hc;
  logic signed [OutW-1:0] hs;
  logic signed [OutW-1:0] cc;
  logic signed [OutW-1:0] cs;
  logic signed [OutW-1:0] cos_nxt;
  logic signed [OutW-1:0] sin_nxt;
  logic                   vld_r;
  logic signed [OutW-1:0] cos_r;
  logic signed [OutW-1:0] sin_r;

  always_comb begin
    hc = d_i.cx[WordW-1 -: OutW];
    hs = d_i.sy[WordW-1 -: OutW];
    cc = (hc > OUT_LIMIT) ? OUT_LIMIT : ((hc < -OUT_LIMIT) ? -OUT_LIMIT : hc);
    cs = (hs > OUT_LIMIT) ? OUT_LIMIT : ((hs < -OUT_LIMIT) ? -OUT_LIMIT : hs);
    cos_nxt = d_i.neg_cos ? -cc : cc;
    sin_nxt = d_i.neg_sin ? -cs : cs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign out_valid  = vld_r;
  assign out_cosine = cos_r;
  assign out_sine   = sin_r;

endmodule
`default_nettype wire

[design/cordic_sine_cosine.sv]
// Throughput: one angle per cycle; one fold stage, one register per CORDIC
// step, one saturation stage. busy is always low.
// Reset (rst_n low, synchronous) clears the valid bits only; requests in
// flight are dropped.
// Top level: CORDIC sine/cosine pipeline.
`default_nettype none
module cordic_sine_cosine #(
  parameter int ITERATIONS = 29
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [15:0]  in_angle,
  output logic         out_valid,
  output logic signed [15:0] out_cosine,
  output logic signed [15:0] out_sine
);
  import ccs_pkg::*;

  logic     vld [ITERATIONS+1];
  ccs_vec_t pipe [ITERATIONS+1];

  assign busy = 1'b0;

  ccs_fold u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (start),
    .angle (in_angle),
    .vld_o (vld[0]),
    .d_o   (pipe[0])
  );

  for (genvar k = 1; k <= ITERATIONS; k++) begin : g_step
    ccs_stage #(.STEP(k)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[k-1]),
      .d_i   (pipe[k-1]),
      .vld_o (vld[k]),
      .d_o   (pipe[k])
    );
  end

  ccs_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld[ITERATIONS]),
    .d_i        (pipe[ITERATIONS]),
    .out_valid  (out_valid),
    .out_cosine (out_cosine),
    .out_sine   (out_sine)
  );

endmodule
`default_nettype wire

[design/ccs_checker.sv]
// Port-level checker for the CORDIC sine/cosine block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module ccs_checker #(
  parameter int ITERATIONS = 29
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_cosine,
  input logic signed [15:0] out_sine
);
  localparam int Lat  = ITERATIONS + 2;
  localparam int CntW = $clog2(Lat + 1);

  logic [CntW-1:0] warm_r;
  logic            warm;
  logic            in_rng;
  logic            nonzero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (warm_r != CntW'(Lat)) begin
      warm_r <= warm_r + 1'b1;
    end
  end

  assign warm     = (warm_r == CntW'(Lat));
  assign in_rng   = (out_cosine <= 16'sd16384) && (out_cosine >= -16'sd16384) &&
                    (out_sine <= 16'sd16384) && (out_sine >= -16'sd16384);
  assign nonzero  = (out_cosine != 16'sd0) || (out_sine != 16'sd0);

  `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  `ASSERT_IMPL(a_result_timing, clk, rst_n, warm, out_valid == $past(start && !busy, Lat))
  `ASSERT_IMPL(a_result_range, clk, rst_n, out_valid, in_rng)
  `ASSERT_IMPL(a_result_nonzero, clk, rst_n, out_valid, nonzero)

endmodule

bind cordic_sine_cosine ccs_checker #(.ITERATIONS(ITERATIONS)) u_ccs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_cosine (out_cosine),
  .out_sine   (out_sine)
);
`default_nettype wire

[test/tb_cordic_sine_cosine.sv]
// Self-checking testbench for the CORDIC sine/cosine pipeline.
module tb_cordic_sine_cosine;
  timeunit 1ns;
  timeprecision 1ps;
  import ccs_pkg::*;

  localparam int Iters = 29;
  localparam int RandomAngles = 1350;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = Iters + 10;

  typedef struct packed {
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
  } sincos_t;

  class sincos_board;
    sincos_t expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function automatic longint sat16(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
    endfunction

    // folds into [0, pi/2], rotates from pi/4, then fixes the quadrant signs
    function automatic sincos_t predict_sincos(logic [15:0] ang);
      longint atan_steps [10] = '{
        248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288
      };
      int unsigned a;
      bit neg_cos, neg_sin;
      longint tgt, acc, c, s, rot, cold, rc, rs;
      sincos_t r;
      a = ang;
      neg_cos = 0;
      neg_sin = 0;
      if (a > TWO_PI) a -= TWO_PI;
      if (a > THREE_HALF_PI) begin
        a = TWO_PI - a;
        neg_sin = 1;
      end else if (a > PI_ANG) begin
        a = a - PI_ANG;
        neg_cos = 1;
        neg_sin = 1;
      end else if (a > HALF_PI) begin
        a = PI_ANG - a;
        neg_cos = 1;
      end
      tgt = longint'(a) * 65536;
      acc = longint'(START_ANGLE);
      c = longint'(START_VECTOR);
      s = longint'(START_VECTOR);
      rot = atan_steps[0];
      for (int i = 1; i <= Iters; i++) begin
        cold = c;
        if (tgt > acc) begin
          c = c - (s >>> i);
          s = (cold >>> i) + s;
          acc += rot;
        end else begin
          c = c + (s >>> i);
          s = s - (cold >>> i);
          acc -= rot;
        end
        if (i < 10) rot = atan_steps[i];
        else rot = rot / 2;
      end
      rc = sat16(c >>> 16);
      rs = sat16(s >>> 16);
      if (neg_cos) rc = -rc;
      if (neg_sin) rs = -rs;
      r.cosine = rc[15:0];
      r.sine = rs[15:0];
      return r;
    endfunction

    function void note_request(logic [15:0] ang);
      expected_q.push_back(predict_sincos(ang));
    endfunction

    task check_result(logic signed [15:0] cosine, logic signed [15:0] sine);
      sincos_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result cos=%0d sin=%0d", cosine, sine));
        return;
      end
      e = expected_q.pop_front();
      if (cosine !== e.cosine)
        report($sformatf("cosine got %0d want %0d", cosine, e.cosine));
      if (sine !== e.sine)
        report($sformatf("sine got %0d want %0d", sine, e.sine));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [15:0] in_angle;
  logic out_valid;
  logic signed [15:0] out_cosine;
  logic signed [15:0] out_sine;

  sincos_board board;
  int cycles;

  cordic_sine_cosine #(.ITERATIONS(Iters)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_angle(in_angle),
    .out_valid(out_valid),
    .out_cosine(out_cosine),
    .out_sine(out_sine)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_request(in_angle);
      if (out_valid) board.check_result(out_cosine, out_sine);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task send_angle(input logic [15:0] a);
    @(negedge clk);
    start <= 1'b1;
    in_angle <= a;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_angle <= 16'($urandom);
    end
  endtask

  function automatic logic [15:0] random_angle();
    logic [15:0] edges [7] = '{0, HALF_PI, PI_ANG, THREE_HALF_PI, TWO_PI, 16'd65535, 16'd6434};
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 16'($urandom);
    if (pick < 85) return 16'($urandom_range(0, TWO_PI));
    return edges[$urandom_range(0, 6)] + 16'($urandom_range(0, 8)) - 16'd4;
  endfunction

  initial begin
    logic [15:0] directed [] = '{
      0, 1, 6434, HALF_PI - 1, HALF_PI, HALF_PI + 1, PI_ANG - 1, PI_ANG, PI_ANG + 1,
      THREE_HALF_PI - 1, THREE_HALF_PI, THREE_HALF_PI + 1, TWO_PI - 1, TWO_PI,
      TWO_PI + 1, 16'd64340, 16'd65535, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555
    };
    int sent;
    int burst;
    board = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_angle = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_angle(directed[i]);
    idle(3);

    sent = 0;
    while (sent < RandomAngles) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < RandomAngles; k++) begin
        send_angle(random_angle());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
    end
    idle(1);

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
